// ===== rtl/c2dmac_pkg.sv =====
package c2dmac_pkg;

  localparam int PIXEL_WORDS      = 1024;
  localparam int WEIGHT_WORDS     = 1024;
  localparam int MAX_OUT_CHANNELS = 16;

  localparam int PIX_AW  = $clog2(PIXEL_WORDS);
  localparam int WT_AW   = $clog2(WEIGHT_WORDS);
  localparam int BIAS_AW = (MAX_OUT_CHANNELS > 1) ? $clog2(MAX_OUT_CHANNELS) : 1;

  localparam int ACC_W     = 40;
  localparam int DIV_STEPS = 14;
  localparam int DIV_CW    = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    MODE_WEIGHT  = 2'd0,
    MODE_BIAS    = 2'd1,
    MODE_PIXEL   = 2'd2,
    MODE_COMPUTE = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    REG_IN_CHANNELS   = 3'd0,
    REG_IN_HEIGHT     = 3'd1,
    REG_IN_WIDTH      = 3'd2,
    REG_OUT_CHANNELS  = 3'd3,
    REG_KERNEL_HEIGHT = 3'd4,
    REG_KERNEL_WIDTH  = 3'd5
  } reg_e;

  typedef struct packed {
    logic [2:0] in_c;
    logic [5:0] in_h;
    logic [5:0] in_w;
    logic [4:0] out_c;
    logic [2:0] kh;
    logic [2:0] kw;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    in_c:  3'd1,
    in_h:  6'd28,
    in_w:  6'd28,
    out_c: 5'd4,
    kh:    3'd3,
    kw:    3'd3
  };

  typedef struct packed {
    logic               pix_we;
    logic               wt_we;
    logic               bias_we;
    logic [13:0]        addr;
    logic signed [15:0] data;
  } load_t;

  typedef struct packed {
    logic              valid;
    logic              err;
    logic [4:0]        oc;
    logic [PIX_AW-1:0] pix_start;
    logic [WT_AW-1:0]  wt_start;
    logic [8:0]        count;
    logic [11:0]       hw;
  } job_t;

  typedef struct packed {
    logic                    valid;
    logic                    status;
    logic signed [ACC_W-1:0] result;
  } res_t;

endpackage

// ===== rtl/c2dmac_addr.sv =====
module c2dmac_addr (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [13:0]         index_i,
  input  c2dmac_pkg::cfg_t    cfg_i,
  output c2dmac_pkg::job_t    job_o
);

  localparam logic [2:0] A_IDLE  = 3'd0;
  localparam logic [2:0] A_DIM   = 3'd1;
  localparam logic [2:0] A_RANGE = 3'd2;
  localparam logic [2:0] A_DIV1  = 3'd3;
  localparam logic [2:0] A_DIV2  = 3'd4;
  localparam logic [2:0] A_CHK1  = 3'd5;
  localparam logic [2:0] A_CHK2  = 3'd6;

  localparam logic [c2dmac_pkg::DIV_CW-1:0] DIV_LAST =
    c2dmac_pkg::DIV_CW'(c2dmac_pkg::DIV_STEPS - 1);

  logic [2:0]                      state_q, state_d;
  logic [c2dmac_pkg::DIV_CW-1:0]   dcnt_q, dcnt_d;
  c2dmac_pkg::job_t                job_q, job_d;

  logic [13:0] idx_q;
  logic [5:0]  out_w_q;
  logic [11:0] plane_q;
  logic [11:0] hw_q;
  logic [5:0]  kvol_q;
  logic [8:0]  ckv_q;
  logic [14:0] chbase_q;
  logic [8:0]  khw_q;
  logic [13:0] dq_q;
  logic [11:0] dr_q;
  logic [11:0] dsor_q;
  logic [4:0]  oc_q;
  logic [5:0]  r_q;
  logic [5:0]  c_q;
  logic [11:0] rw_q;
  logic [14:0] wt_end_q;

  logic [5:0]  out_h_c, out_w_c;
  logic        dim_err;
  logic [16:0] total_c;
  logic        range_err;
  logic [12:0] trial;
  logic [12:0] diff;
  logic        ge;
  logic [13:0] dq_n;
  logic [11:0] dr_n;
  logic [15:0] last_px;
  logic        chk_err;

  assign out_h_c = cfg_i.in_h - 6'(cfg_i.kh) + 6'd1;
  assign out_w_c = cfg_i.in_w - 6'(cfg_i.kw) + 6'd1;

  assign dim_err = (cfg_i.in_c == 3'd0) || (cfg_i.in_h == 6'd0) || (cfg_i.in_w == 6'd0) ||
                   (cfg_i.out_c == 5'd0) || (cfg_i.kh == 3'd0) || (cfg_i.kw == 3'd0) ||
                   (6'(cfg_i.kh) > cfg_i.in_h) || (6'(cfg_i.kw) > cfg_i.in_w);

  assign total_c   = 17'(cfg_i.out_c) * 17'(plane_q);
  assign range_err = 17'(idx_q) >= total_c;

  // Restoring divider, one quotient bit per cycle
  assign trial = {dr_q, dq_q[13]};
  assign ge    = trial >= {1'b0, dsor_q};
  assign diff  = trial - {1'b0, dsor_q};
  assign dr_n  = ge ? diff[11:0] : trial[11:0];
  assign dq_n  = {dq_q[12:0], ge};

  assign last_px = 16'(chbase_q) + 16'(rw_q) + 16'(khw_q) + 16'(c_q) +
                   16'(cfg_i.kw) - 16'd1;
  assign chk_err = (32'(oc_q) >= c2dmac_pkg::MAX_OUT_CHANNELS) ||
                   (32'(last_px) >= c2dmac_pkg::PIXEL_WORDS) ||
                   (32'(wt_end_q) > c2dmac_pkg::WEIGHT_WORDS);

  always_comb begin
    state_d     = state_q;
    dcnt_d      = dcnt_q;
    job_d       = job_q;
    job_d.valid = 1'b0;
    case (state_q)
      A_IDLE: begin
        if (start_i) begin
          state_d = A_DIM;
        end
      end
      A_DIM: begin
        if (dim_err) begin
          job_d.valid = 1'b1;
          job_d.err   = 1'b1;
          state_d     = A_IDLE;
        end else begin
          state_d = A_RANGE;
        end
      end
      A_RANGE: begin
        if (range_err) begin
          job_d.valid = 1'b1;
          job_d.err   = 1'b1;
          state_d     = A_IDLE;
        end else begin
          dcnt_d  = '0;
          state_d = A_DIV1;
        end
      end
      A_DIV1: begin
        if (dcnt_q == DIV_LAST) begin
          dcnt_d  = '0;
          state_d = A_DIV2;
        end else begin
          dcnt_d = dcnt_q + 1'b1;
        end
      end
      A_DIV2: begin
        if (dcnt_q == DIV_LAST) begin
          dcnt_d  = '0;
          state_d = A_CHK1;
        end else begin
          dcnt_d = dcnt_q + 1'b1;
        end
      end
      A_CHK1: begin
        state_d = A_CHK2;
      end
      A_CHK2: begin
        job_d.valid     = 1'b1;
        job_d.err       = chk_err;
        job_d.oc        = oc_q;
        job_d.pix_start = c2dmac_pkg::PIX_AW'(rw_q + 12'(c_q));
        job_d.wt_start  = c2dmac_pkg::WT_AW'(wt_end_q - 15'(ckv_q));
        job_d.count     = ckv_q;
        job_d.hw        = hw_q;
        state_d         = A_IDLE;
      end
      default: begin
        state_d = A_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      dcnt_q  <= '0;
      job_q   <= '0;
    end else begin
      state_q <= state_d;
      dcnt_q  <= dcnt_d;
      job_q   <= job_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      A_IDLE: begin
        if (start_i) begin
          idx_q <= index_i;
        end
      end
      A_DIM: begin
        out_w_q <= out_w_c;
        plane_q <= 12'(out_h_c) * 12'(out_w_c);
        hw_q    <= 12'(cfg_i.in_h) * 12'(cfg_i.in_w);
        kvol_q  <= 6'(cfg_i.kh) * 6'(cfg_i.kw);
      end
      A_RANGE: begin
        ckv_q    <= 9'(cfg_i.in_c) * 9'(kvol_q);
        chbase_q <= 15'(cfg_i.in_c - 3'd1) * 15'(hw_q);
        khw_q    <= 9'(cfg_i.kh - 3'd1) * 9'(cfg_i.in_w);
        dq_q     <= idx_q;
        dr_q     <= '0;
        dsor_q   <= plane_q;
      end
      A_DIV1: begin
        if (dcnt_q == DIV_LAST) begin
          // channel is below out_channels, so five bits hold it
          oc_q   <= dq_n[4:0];
          dq_q   <= 14'(dr_n);
          dr_q   <= '0;
          dsor_q <= 12'(out_w_q);
        end else begin
          dq_q <= dq_n;
          dr_q <= dr_n;
        end
      end
      A_DIV2: begin
        dq_q <= dq_n;
        dr_q <= dr_n;
        if (dcnt_q == DIV_LAST) begin
          r_q <= dq_n[5:0];
          c_q <= dr_n[5:0];
        end
      end
      A_CHK1: begin
        rw_q     <= 12'(r_q) * 12'(cfg_i.in_w);
        wt_end_q <= (15'(oc_q) + 15'd1) * 15'(ckv_q);
      end
      default: begin
      end
    endcase
  end

  assign job_o = job_q;

`ifndef NO_ASSERTIONS
  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == A_DIV1 || state_q == A_DIV2) |-> dcnt_q <= DIV_LAST)
    else $error("divider step count out of range");
`endif

endmodule

// ===== rtl/c2dmac_mac.sv =====
module c2dmac_mac (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  c2dmac_pkg::load_t   load_i,
  input  c2dmac_pkg::cfg_t    cfg_i,
  input  c2dmac_pkg::job_t    job_i,
  input  logic                take_i,
  output c2dmac_pkg::res_t    res_o
);

  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_BIAS = 2'd1;
  localparam logic [1:0] M_RUN  = 2'd2;
  localparam logic [1:0] M_FIN  = 2'd3;

  logic signed [15:0] pix_mem  [c2dmac_pkg::PIXEL_WORDS];
  logic signed [15:0] wt_mem   [c2dmac_pkg::WEIGHT_WORDS];
  logic signed [15:0] bias_mem [c2dmac_pkg::MAX_OUT_CHANNELS];

  logic [1:0] state_q, state_d;
  logic [8:0] left_q;
  logic       rv_q;
  logic       pv_q;

  logic [c2dmac_pkg::PIX_AW-1:0] rowbase_q, chanbase_q;
  logic [c2dmac_pkg::WT_AW-1:0]  wa_q;
  logic [2:0]                    kc_q, kr_q;
  logic [11:0]                   hw_q;
  logic                          status_q;
  logic signed [15:0]            pix_rd_q, wt_rd_q, bias_rd_q;
  logic signed [31:0]            prod_q;
  logic signed [c2dmac_pkg::ACC_W-1:0] acc_q;

  logic                          issue;
  logic                          drained;
  logic [c2dmac_pkg::PIX_AW-1:0] pix_addr;
  logic                          kc_last, kr_last;

  assign issue    = (state_q == M_RUN) && (left_q != 9'd0);
  assign drained  = (left_q == 9'd0) && !rv_q && !pv_q;
  assign pix_addr = rowbase_q + c2dmac_pkg::PIX_AW'(kc_q);
  assign kc_last  = kc_q == cfg_i.kw - 3'd1;
  assign kr_last  = kr_q == cfg_i.kh - 3'd1;

  always_ff @(posedge clk_i) begin
    if (load_i.pix_we) begin
      pix_mem[c2dmac_pkg::PIX_AW'(load_i.addr)] <= load_i.data;
    end
    pix_rd_q <= pix_mem[pix_addr];
  end

  always_ff @(posedge clk_i) begin
    if (load_i.wt_we) begin
      wt_mem[c2dmac_pkg::WT_AW'(load_i.addr)] <= load_i.data;
    end
    wt_rd_q <= wt_mem[wa_q];
  end

  always_ff @(posedge clk_i) begin
    if (load_i.bias_we) begin
      bias_mem[c2dmac_pkg::BIAS_AW'(load_i.addr)] <= load_i.data;
    end
    bias_rd_q <= bias_mem[c2dmac_pkg::BIAS_AW'(job_i.oc)];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      M_IDLE: begin
        if (job_i.valid) begin
          state_d = job_i.err ? M_FIN : M_BIAS;
        end
      end
      M_BIAS: begin
        state_d = M_RUN;
      end
      M_RUN: begin
        if (drained) begin
          state_d = M_FIN;
        end
      end
      M_FIN: begin
        if (take_i) begin
          state_d = M_IDLE;
        end
      end
      default: begin
        state_d = M_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      left_q  <= '0;
      rv_q    <= 1'b0;
      pv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      rv_q    <= issue;
      pv_q    <= rv_q;
      if (state_q == M_IDLE && job_i.valid && !job_i.err) begin
        left_q <= job_i.count;
      end else if (issue) begin
        left_q <= left_q - 9'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == M_IDLE && job_i.valid) begin
      rowbase_q  <= job_i.pix_start;
      chanbase_q <= job_i.pix_start;
      wa_q       <= job_i.wt_start;
      hw_q       <= job_i.hw;
      kc_q       <= '0;
      kr_q       <= '0;
      status_q   <= job_i.err;
      acc_q      <= '0;
    end else if (state_q == M_BIAS) begin
      // bias is Q4.12, align it to Q16.24
      acc_q <= {{(c2dmac_pkg::ACC_W - 28){bias_rd_q[15]}}, bias_rd_q, 12'd0};
    end else begin
      if (issue) begin
        wa_q <= wa_q + 1'b1;
        if (!kc_last) begin
          kc_q <= kc_q + 3'd1;
        end else begin
          kc_q <= '0;
          if (kr_last) begin
            // advance to the same window in the next input channel
            kr_q       <= '0;
            chanbase_q <= chanbase_q + c2dmac_pkg::PIX_AW'(hw_q);
            rowbase_q  <= chanbase_q + c2dmac_pkg::PIX_AW'(hw_q);
          end else begin
            kr_q      <= kr_q + 3'd1;
            rowbase_q <= rowbase_q + c2dmac_pkg::PIX_AW'(cfg_i.in_w);
          end
        end
      end
      if (pv_q) begin
        acc_q <= acc_q + {{(c2dmac_pkg::ACC_W - 32){prod_q[31]}}, prod_q};
      end
    end
    if (rv_q) begin
      prod_q <= pix_rd_q * wt_rd_q;
    end
  end

  assign res_o.valid  = state_q == M_FIN;
  assign res_o.status = status_q;
  assign res_o.result = acc_q;

`ifndef NO_ASSERTIONS
  a_acc_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rv_q || pv_q) |-> state_q == M_RUN)
    else $error("product pipeline active outside the run phase");
`endif

endmodule

// ===== rtl/conv2d_valid_mac_core.sv =====
// Compute transaction: after acceptance the 14-step divider is used twice for the index decode,
// then one MAC per cycle runs through the pixel and weight memory read ports until the
// result appears.
// Out-of-range requests answer with an error status and a zero result. Loads are taken while the core is not busy.
// The input stall drops as a compute result enters the output register, so the next transaction can then be accepted.
// Reset clears control state and loads the register defaults; store contents stay undefined.
module conv2d_valid_mac_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          mode_i,
  input  logic [13:0]         index_i,
  input  logic signed [15:0]  value_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [39:0]  result_o,
  output logic                status_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  c2dmac_pkg::cfg_t  cfg_q;
  c2dmac_pkg::load_t load;
  c2dmac_pkg::job_t  job;
  c2dmac_pkg::res_t  res;

  logic                          busy_q, busy_d;
  logic                          out_valid_q;
  logic signed [c2dmac_pkg::ACC_W-1:0] result_q;
  logic                          status_q;

  logic in_acc;
  logic start;
  logic take;
  logic cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= c2dmac_pkg::CFG_RESET;
    end else if (cfg_we) begin
      case (paddr[4:2])
        c2dmac_pkg::REG_IN_CHANNELS:   cfg_q.in_c  <= pwdata[2:0];
        c2dmac_pkg::REG_IN_HEIGHT:     cfg_q.in_h  <= pwdata[5:0];
        c2dmac_pkg::REG_IN_WIDTH:      cfg_q.in_w  <= pwdata[5:0];
        c2dmac_pkg::REG_OUT_CHANNELS:  cfg_q.out_c <= pwdata[4:0];
        c2dmac_pkg::REG_KERNEL_HEIGHT: cfg_q.kh    <= pwdata[2:0];
        c2dmac_pkg::REG_KERNEL_WIDTH:  cfg_q.kw    <= pwdata[2:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      c2dmac_pkg::REG_IN_CHANNELS:   prdata = 32'(cfg_q.in_c);
      c2dmac_pkg::REG_IN_HEIGHT:     prdata = 32'(cfg_q.in_h);
      c2dmac_pkg::REG_IN_WIDTH:      prdata = 32'(cfg_q.in_w);
      c2dmac_pkg::REG_OUT_CHANNELS:  prdata = 32'(cfg_q.out_c);
      c2dmac_pkg::REG_KERNEL_HEIGHT: prdata = 32'(cfg_q.kh);
      c2dmac_pkg::REG_KERNEL_WIDTH:  prdata = 32'(cfg_q.kw);
      default:                       prdata = '0;
    endcase
  end

  assign in_stall_o = busy_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign start      = in_acc && (mode_i == c2dmac_pkg::MODE_COMPUTE);

  // Drop loads that fall beyond their store
  assign load.pix_we  = in_acc && (mode_i == c2dmac_pkg::MODE_PIXEL) &&
                        (32'(index_i) < c2dmac_pkg::PIXEL_WORDS);
  assign load.wt_we   = in_acc && (mode_i == c2dmac_pkg::MODE_WEIGHT) &&
                        (32'(index_i) < c2dmac_pkg::WEIGHT_WORDS);
  assign load.bias_we = in_acc && (mode_i == c2dmac_pkg::MODE_BIAS) &&
                        (32'(index_i) < c2dmac_pkg::MAX_OUT_CHANNELS);
  assign load.addr    = index_i;
  assign load.data    = value_i;

  c2dmac_addr u_addr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .index_i (index_i),
    .cfg_i   (cfg_q),
    .job_o   (job)
  );

  c2dmac_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (load),
    .cfg_i  (cfg_q),
    .job_i  (job),
    .take_i (take),
    .res_o  (res)
  );

  assign take = !out_valid_q || !out_stall_i;

  always_comb begin
    busy_d = busy_q;
    if (start) begin
      busy_d = 1'b1;
    end else if (res.valid && take) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      if (res.valid && take) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid && take) begin
      result_q <= res.status ? '0 : res.result;
      status_q <= res.status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;
  assign status_o    = status_q;

`ifndef NO_ASSERTIONS
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |-> result_o == '0)
    else $error("error response carries a nonzero result");
  a_busy_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res.valid && take) |=> !busy_q)
    else $error("input still stalled after result hand-off");
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job.valid |-> busy_q)
    else $error("address job issued with no compute in flight");
`endif

endmodule
